// ===== design/slt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, codes and character helpers of the tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int LINE_BITS_DEF   = 24;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic [9:0] DIGIT_MAX = 10'd1023;

  // Record types.
  localparam logic [1:0] REC_TOKEN = 2'd0;
  localparam logic [1:0] REC_CHAR  = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  // Token kinds other than operators.
  localparam logic [5:0] TK_END    = 6'd0;
  localparam logic [5:0] TK_IDENT  = 6'd1;
  localparam logic [5:0] TK_INT    = 6'd2;
  localparam logic [5:0] TK_STRING = 6'd3;

  // Error codes.
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd0;
  localparam logic [2:0] ERR_HEX_EMPTY  = 3'd1;
  localparam logic [2:0] ERR_BIN_EMPTY  = 3'd2;
  localparam logic [2:0] ERR_NUM_SUFFIX = 3'd3;
  localparam logic [2:0] ERR_OPEN_STR   = 3'd4;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd5;

  typedef enum logic [3:0] {
    LM_IDLE, LM_IDENT, LM_DEC, LM_HEX_FIRST, LM_HEX, LM_BIN_FIRST, LM_BIN,
    LM_STR, LM_ESC, LM_LINE_CMT, LM_BLOCK_CMT
  } lex_mode_t;

  typedef enum logic [1:0] {EV_NOP, EV_BYTE, EV_FINISH} ev_kind_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  c;
    logic        p1v;
    logic [7:0]  p1;
    logic        p2v;
    logic [7:0]  p2;
    logic        eoi;
  } event_t;

  // Position-free part of one result.
  typedef struct packed {
    logic [1:0]  rtype;
    logic [5:0]  kind;
    logic [63:0] val;
    logic [9:0]  dig;
    logic [7:0]  ch;
    logic [2:0]  err;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] len;
    logic [5:0] kind;
  } op_hit_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_dec(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = (c <= "9") ? (c - "0") : ((c | 8'h20) - "a" + 8'd10);
    return t[3:0];
  endfunction

  function automatic res_t mk_res(input logic [1:0] rtype, input logic [5:0] kind,
                                  input logic [63:0] val, input logic [9:0] dig,
                                  input logic [7:0] ch, input logic [2:0] err);
    res_t r;
    r.rtype = rtype;
    r.kind  = kind;
    r.val   = val;
    r.dig   = dig;
    r.ch    = ch;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

  // Longest operator match; three-character forms win over two, two over one.
  function automatic op_hit_t op_lookup(input logic [7:0] c,
                                        input logic p1v, input logic [7:0] p1,
                                        input logic p2v, input logic [7:0] p2);
    op_hit_t o;
    logic a_eq, a_u, a_lt, a_gt, a_amp, a_bar, a_dot, a_s, b_u, b_gt;
    a_eq  = p1v && p1 == "=";
    a_u   = p1v && p1 == "u";
    a_lt  = p1v && p1 == "<";
    a_gt  = p1v && p1 == ">";
    a_amp = p1v && p1 == "&";
    a_bar = p1v && p1 == "|";
    a_dot = p1v && p1 == ".";
    a_s   = p1v && p1 == "s";
    b_u   = p2v && p2 == "u";
    b_gt  = p2v && p2 == ">";
    o.hit = 1'b1;
    o.len = 2'd1;
    o.kind = 6'd0;
    case (c)
      "<": begin
        if (a_eq && b_u) begin o.kind = 6'd25; o.len = 2'd3; end
        else if (a_u) begin o.kind = 6'd24; o.len = 2'd2; end
        else if (a_eq) begin o.kind = 6'd21; o.len = 2'd2; end
        else if (a_lt) begin o.kind = 6'd40; o.len = 2'd2; end
        else o.kind = 6'd20;
      end
      ">": begin
        if (a_eq && b_u) begin o.kind = 6'd27; o.len = 2'd3; end
        else if (a_gt && b_gt) begin o.kind = 6'd42; o.len = 2'd3; end
        else if (a_u) begin o.kind = 6'd26; o.len = 2'd2; end
        else if (a_eq) begin o.kind = 6'd23; o.len = 2'd2; end
        else if (a_gt) begin o.kind = 6'd41; o.len = 2'd2; end
        else o.kind = 6'd22;
      end
      "=": begin
        if (a_eq) begin o.kind = 6'd18; o.len = 2'd2; end
        else o.kind = 6'd17;
      end
      "!": begin
        if (a_eq) begin o.kind = 6'd19; o.len = 2'd2; end
        else o.kind = 6'd39;
      end
      "&": begin
        if (a_amp) begin o.kind = 6'd43; o.len = 2'd2; end
        else o.kind = 6'd35;
      end
      "|": begin
        if (a_bar) begin o.kind = 6'd44; o.len = 2'd2; end
        else o.kind = 6'd36;
      end
      "-": begin
        if (a_gt) begin o.kind = 6'd16; o.len = 2'd2; end
        else o.kind = 6'd29;
      end
      ".": begin
        if (a_dot) begin o.kind = 6'd14; o.len = 2'd2; end
        else o.kind = 6'd13;
      end
      "/": begin
        if (a_s) begin o.kind = 6'd32; o.len = 2'd2; end
        else o.kind = 6'd31;
      end
      "%": begin
        if (a_s) begin o.kind = 6'd34; o.len = 2'd2; end
        else o.kind = 6'd33;
      end
      "{": o.kind = 6'd4;
      "}": o.kind = 6'd5;
      "(": o.kind = 6'd6;
      ")": o.kind = 6'd7;
      "[": o.kind = 6'd8;
      "]": o.kind = 6'd9;
      ",": o.kind = 6'd10;
      ";": o.kind = 6'd11;
      ":": o.kind = 6'd12;
      "?": o.kind = 6'd15;
      "+": o.kind = 6'd28;
      "*": o.kind = 6'd30;
      "^": o.kind = 6'd37;
      "~": o.kind = 6'd38;
      default: o.hit = 1'b0;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== design/slt_evq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slt_evq
// Short event queue between the front and the back of the tokenizer.
// ----------------------------------------------------------------------------
module slt_evq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire slt_pkg::event_t push_ev,
  output logic                 full,
  output logic                 avail,
  output slt_pkg::event_t      head_ev,
  input  wire logic            pop
);

  localparam int DEPTH = slt_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);

  slt_pkg::event_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign avail   = (cnt_r != '0);
  assign head_ev = mem_r[rp_r];

  // Storage is written only on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ev;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("event queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !avail |-> !pop)
    else $error("event queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("event queue count out of range");

endmodule
`default_nettype wire

// ===== design/slt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slt_front
// Input side: lookahead window and event generation, one event per item,
// plus a flush sequence at the end of a text.
// ----------------------------------------------------------------------------
module slt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_char_byte,
  input  wire logic            in_char_present,
  input  wire logic            in_is_last,
  input  wire logic            q_full,
  output logic                 q_push,
  output slt_pkg::event_t      q_ev
);

  logic [7:0] w0_r, w1_r, w0_nxt, w1_nxt;
  logic [1:0] wcnt_r, wcnt_nxt;
  logic       flush_r, flush_nxt;
  logic [7:0] fb0_r, fb1_r, fb2_r, fb0_nxt, fb1_nxt, fb2_nxt;
  logic [1:0] flen_r, flen_nxt;
  logic       acc;

  assign in_stall = flush_r || q_full;
  assign acc = in_valid && !in_stall;

  // Window update and event selection.
  always_comb begin
    w0_nxt = w0_r;
    w1_nxt = w1_r;
    wcnt_nxt = wcnt_r;
    flush_nxt = flush_r;
    fb0_nxt = fb0_r;
    fb1_nxt = fb1_r;
    fb2_nxt = fb2_r;
    flen_nxt = flen_r;
    q_push = 1'b0;
    q_ev = '0;
    q_ev.kind = slt_pkg::EV_NOP;
    q_ev.eoi = 1'b1;
    if (flush_r) begin
      if (!q_full) begin
        q_push = 1'b1;
        if (flen_r != 2'd0) begin
          q_ev.kind = slt_pkg::EV_BYTE;
          q_ev.c = fb0_r;
          q_ev.p1v = (flen_r > 2'd1);
          q_ev.p1 = fb1_r;
          q_ev.p2v = (flen_r > 2'd2);
          q_ev.p2 = fb2_r;
          q_ev.eoi = 1'b0;
          fb0_nxt = fb1_r;
          fb1_nxt = fb2_r;
          flen_nxt = flen_r - 2'd1;
        end else begin
          q_ev.kind = slt_pkg::EV_FINISH;
          flush_nxt = 1'b0;
        end
      end
    end else if (acc) begin
      if (in_is_last) begin
        // Gather the window and the final byte, then drain them.
        fb0_nxt = w0_r;
        fb1_nxt = w1_r;
        fb2_nxt = in_char_byte;
        if (wcnt_r == 2'd0) fb0_nxt = in_char_byte;
        if (wcnt_r == 2'd1) fb1_nxt = in_char_byte;
        flen_nxt = wcnt_r + {1'b0, in_char_present};
        flush_nxt = 1'b1;
        wcnt_nxt = 2'd0;
      end else begin
        q_push = 1'b1;
        if (in_char_present) begin
          if (wcnt_r == 2'd2) begin
            q_ev.kind = slt_pkg::EV_BYTE;
            q_ev.c = w0_r;
            q_ev.p1v = 1'b1;
            q_ev.p1 = w1_r;
            q_ev.p2v = 1'b1;
            q_ev.p2 = in_char_byte;
            w0_nxt = w1_r;
            w1_nxt = in_char_byte;
          end else begin
            if (wcnt_r == 2'd0) w0_nxt = in_char_byte;
            else w1_nxt = in_char_byte;
            wcnt_nxt = wcnt_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r  <= 2'd0;
      flush_r <= 1'b0;
      flen_r  <= 2'd0;
    end else begin
      wcnt_r  <= wcnt_nxt;
      flush_r <= flush_nxt;
      flen_r  <= flen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w0_r  <= w0_nxt;
    w1_r  <= w1_nxt;
    fb0_r <= fb0_nxt;
    fb1_r <= fb1_nxt;
    fb2_r <= fb2_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) wcnt_r != 2'd3)
    else $error("lookahead window overfilled");
  assert property (@(posedge clk) disable iff (!rst_n) flush_r |-> wcnt_r == 2'd0)
    else $error("window not empty during flush");
  assert property (@(posedge clk) disable iff (!rst_n) (acc && in_is_last) |=> flush_r)
    else $error("end of text did not start a flush");

endmodule
`default_nettype wire

// ===== design/slt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slt_back
// Lexer state machine: scans one event per cycle when not stalled, drives the
// result register and spills a second result of the same event into a pending slot.
// ----------------------------------------------------------------------------
module slt_back #(
  parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = slt_pkg::COLUMN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   ev_avail,
  input  wire slt_pkg::event_t        ev,
  output logic                        ev_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_record_type,
  output logic [5:0]                  out_token_kind,
  output logic [LINE_BITS-1:0]        out_start_line,
  output logic [COLUMN_BITS-1:0]      out_start_column,
  output logic [63:0]                 out_int_value,
  output logic [9:0]                  out_digit_count,
  output logic [7:0]                  out_text_char,
  output logic [2:0]                  out_error_code,
  output logic                        out_last_of_run
);

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

  slt_pkg::lex_mode_t mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   cl_r, cl_nxt, tl_r, tl_nxt;
  logic [COLUMN_BITS-1:0] cc_r, cc_nxt, tc_r, tc_nxt;
  logic [63:0] num_r, num_nxt;
  logic [9:0]  dig_r, dig_nxt, dig_out, dig_inc;
  logic        halt_r, halt_nxt;
  logic [1:0]  skip_r, skip_nxt;

  slt_pkg::res_t          rf [2];
  logic [LINE_BITS-1:0]   rl [2];
  logic [COLUMN_BITS-1:0] rc [2];
  logic [1:0]             nres;
  logic                   fail, rescan;
  slt_pkg::op_hit_t       op;
  logic [7:0]             c;

  slt_pkg::res_t          out_f_r, pend_f_r;
  logic [LINE_BITS-1:0]   out_l_r, pend_l_r;
  logic [COLUMN_BITS-1:0] out_c_r, pend_c_r;
  logic                   out_valid_r, pend_r, adv;

  assign c = ev.c;
  assign dig_inc = (dig_r < slt_pkg::DIGIT_MAX) ? dig_r + 10'd1 : dig_r;
  assign dig_out = (mode_r != slt_pkg::LM_HEX) ? dig_r :
                   (dig_r >= 10'd256) ? slt_pkg::DIGIT_MAX : {dig_r[7:0], 2'b00};
  assign op = slt_pkg::op_lookup(c, ev.p1v, ev.p1, ev.p2v, ev.p2);

  // Next lexer state and the results of the head event.
  always_comb begin
    mode_nxt = mode_r;
    cl_nxt = cl_r;
    cc_nxt = cc_r;
    tl_nxt = tl_r;
    tc_nxt = tc_r;
    num_nxt = num_r;
    dig_nxt = dig_r;
    halt_nxt = halt_r;
    skip_nxt = skip_r;
    rf[0] = '0;
    rf[1] = '0;
    rl[0] = '0;
    rl[1] = '0;
    rc[0] = '0;
    rc[1] = '0;
    nres = 2'd0;
    fail = 1'b0;
    rescan = 1'b0;
    case (ev.kind)
      slt_pkg::EV_BYTE: begin
        if (!halt_r) begin
          if (skip_r != 2'd0) begin
            skip_nxt = skip_r - 2'd1;
          end else begin
            // Continue the token in progress.
            unique case (mode_r) inside
              slt_pkg::LM_IDLE: rescan = 1'b1;
              slt_pkg::LM_LINE_CMT: begin
                if (c == 8'h0A) begin
                  mode_nxt = slt_pkg::LM_IDLE;
                  rescan = 1'b1;
                end
              end
              slt_pkg::LM_BLOCK_CMT: begin
                if (c == "*" && ev.p1v && ev.p1 == "/") begin
                  mode_nxt = slt_pkg::LM_IDLE;
                  skip_nxt = 2'd1;
                end
              end
              slt_pkg::LM_IDENT: begin
                if (slt_pkg::is_word(c)) begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_IDENT, '0, '0, c, '0);
                  rl[0] = tl_r;
                  rc[0] = tc_r;
                  nres = 2'd1;
                end else begin
                  mode_nxt = slt_pkg::LM_IDLE;
                  rescan = 1'b1;
                end
              end
              slt_pkg::LM_HEX_FIRST: begin
                if (!slt_pkg::is_hex(c)) begin
                  fail = 1'b1;
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0,
                                          slt_pkg::ERR_HEX_EMPTY);
                  rl[0] = tl_r;
                  rc[0] = tc_r;
                  nres = 2'd1;
                end else begin
                  num_nxt = {num_r[59:0], slt_pkg::hex_val(c)};
                  dig_nxt = dig_inc;
                  mode_nxt = slt_pkg::LM_HEX;
                end
              end
              slt_pkg::LM_BIN_FIRST: begin
                if (c != "0" && c != "1") begin
                  fail = 1'b1;
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0,
                                          slt_pkg::ERR_BIN_EMPTY);
                  rl[0] = tl_r;
                  rc[0] = tc_r;
                  nres = 2'd1;
                end else begin
                  num_nxt = {num_r[62:0], c[0]};
                  dig_nxt = dig_inc;
                  mode_nxt = slt_pkg::LM_BIN;
                end
              end
              slt_pkg::LM_DEC, slt_pkg::LM_HEX, slt_pkg::LM_BIN: begin
                if (c == "_") begin
                  mode_nxt = mode_r;
                end else if (mode_r == slt_pkg::LM_DEC && slt_pkg::is_dec(c)) begin
                  num_nxt = (num_r << 3) + (num_r << 1) + {60'd0, c[3:0]};
                  dig_nxt = dig_inc;
                end else if (mode_r == slt_pkg::LM_HEX && slt_pkg::is_hex(c)) begin
                  num_nxt = {num_r[59:0], slt_pkg::hex_val(c)};
                  dig_nxt = dig_inc;
                end else if (mode_r == slt_pkg::LM_BIN && (c == "0" || c == "1")) begin
                  num_nxt = {num_r[62:0], c[0]};
                  dig_nxt = dig_inc;
                end else if (slt_pkg::is_word(c)) begin
                  fail = 1'b1;
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0,
                                          slt_pkg::ERR_NUM_SUFFIX);
                  rl[0] = cl_r;
                  rc[0] = cc_r;
                  nres = 2'd1;
                end else begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_TOKEN, slt_pkg::TK_INT, num_r,
                                          dig_out, '0, '0);
                  rl[0] = tl_r;
                  rc[0] = tc_r;
                  nres = 2'd1;
                  mode_nxt = slt_pkg::LM_IDLE;
                  rescan = 1'b1;
                end
              end
              slt_pkg::LM_STR: begin
                if (c == 8'h0A) begin
                  fail = 1'b1;
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0,
                                          slt_pkg::ERR_OPEN_STR);
                  rl[0] = tl_r;
                  rc[0] = tc_r;
                  nres = 2'd1;
                end else if (c == "\"") begin
                  mode_nxt = slt_pkg::LM_IDLE;
                end else if (c == "\\") begin
                  mode_nxt = slt_pkg::LM_ESC;
                end else begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, '0, '0, c, '0);
                  rl[0] = tl_r;
                  rc[0] = tc_r;
                  nres = 2'd1;
                end
              end
              slt_pkg::LM_ESC: begin
                mode_nxt = slt_pkg::LM_STR;
                rl[0] = tl_r;
                rc[0] = tc_r;
                rl[1] = tl_r;
                rc[1] = tc_r;
                nres = 2'd1;
                if (c == "n") begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, '0, '0,
                                          8'h0A, '0);
                end else if (c == "t") begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, '0, '0,
                                          8'h09, '0);
                end else if (c == "\\" || c == "\"") begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, '0, '0, c, '0);
                end else if (c == "{" || c == "}" || c == "[" || c == "]") begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, '0, '0,
                                          "\\", '0);
                  rf[1] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, '0, '0, c, '0);
                  nres = 2'd2;
                end else begin
                  fail = 1'b1;
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0,
                                          slt_pkg::ERR_BAD_ESC);
                  rl[0] = cl_r;
                  rc[0] = cc_r;
                end
              end
              default: begin
                mode_nxt = slt_pkg::LM_IDLE;
                rescan = 1'b1;
              end
            endcase

            // Start of a new token from the idle state.
            if (rescan) begin
              if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
                mode_nxt = slt_pkg::LM_IDLE;
              end else if (c == "/" && ev.p1v && ev.p1 == "/") begin
                mode_nxt = slt_pkg::LM_LINE_CMT;
              end else if (c == "/" && ev.p1v && ev.p1 == "*") begin
                mode_nxt = slt_pkg::LM_BLOCK_CMT;
                skip_nxt = 2'd1;
              end else begin
                tl_nxt = cl_r;
                tc_nxt = cc_r;
                rl[nres[0]] = cl_r;
                rc[nres[0]] = cc_r;
                if (slt_pkg::is_alpha(c)) begin
                  rf[0] = slt_pkg::mk_res(slt_pkg::REC_TOKEN, slt_pkg::TK_IDENT, '0, '0, '0, '0);
                  rf[1] = slt_pkg::mk_res(slt_pkg::REC_CHAR, slt_pkg::TK_IDENT, '0, '0, c, '0);
                  rl[1] = cl_r;
                  rc[1] = cc_r;
                  nres = 2'd2;
                  mode_nxt = slt_pkg::LM_IDENT;
                end else if (slt_pkg::is_dec(c)) begin
                  num_nxt = 64'd0;
                  dig_nxt = 10'd0;
                  if (c == "0" && ev.p1v && (ev.p1 == "x" || ev.p1 == "X")) begin
                    mode_nxt = slt_pkg::LM_HEX_FIRST;
                    skip_nxt = 2'd1;
                  end else if (c == "0" && ev.p1v && (ev.p1 == "b" || ev.p1 == "B")) begin
                    mode_nxt = slt_pkg::LM_BIN_FIRST;
                    skip_nxt = 2'd1;
                  end else begin
                    num_nxt = {60'd0, c[3:0]};
                    dig_nxt = 10'd1;
                    mode_nxt = slt_pkg::LM_DEC;
                  end
                end else if (c == "\"") begin
                  rf[nres[0]] = slt_pkg::mk_res(slt_pkg::REC_TOKEN, slt_pkg::TK_STRING,
                                                '0, '0, '0, '0);
                  nres = nres + 2'd1;
                  mode_nxt = slt_pkg::LM_STR;
                end else if (op.hit) begin
                  rf[nres[0]] = slt_pkg::mk_res(slt_pkg::REC_TOKEN, op.kind, '0, '0, '0, '0);
                  nres = nres + 2'd1;
                  skip_nxt = op.len - 2'd1;
                  mode_nxt = slt_pkg::LM_IDLE;
                end else begin
                  fail = 1'b1;
                  rf[nres[0]] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0,
                                                slt_pkg::ERR_BAD_CHAR);
                  nres = nres + 2'd1;
                end
              end
            end
          end

          // Position tracking, saturating.
          if (!fail) begin
            if (c == 8'h0A) begin
              if (cl_r != {LINE_BITS{1'b1}}) cl_nxt = cl_r + LINE_ONE;
              cc_nxt = COL_ONE;
            end else if (cc_r != {COLUMN_BITS{1'b1}}) begin
              cc_nxt = cc_r + COL_ONE;
            end
          end
        end
      end
      slt_pkg::EV_FINISH: begin
        if (!halt_r) begin
          rl[0] = tl_r;
          rc[0] = tc_r;
          case (mode_r) inside
            slt_pkg::LM_HEX_FIRST: begin
              fail = 1'b1;
              rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0, slt_pkg::ERR_HEX_EMPTY);
              nres = 2'd1;
            end
            slt_pkg::LM_BIN_FIRST: begin
              fail = 1'b1;
              rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0, slt_pkg::ERR_BIN_EMPTY);
              nres = 2'd1;
            end
            slt_pkg::LM_DEC, slt_pkg::LM_HEX, slt_pkg::LM_BIN: begin
              rf[0] = slt_pkg::mk_res(slt_pkg::REC_TOKEN, slt_pkg::TK_INT, num_r, dig_out,
                                      '0, '0);
              nres = 2'd1;
            end
            slt_pkg::LM_STR: begin
              fail = 1'b1;
              rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0, slt_pkg::ERR_OPEN_STR);
              nres = 2'd1;
            end
            slt_pkg::LM_ESC: begin
              fail = 1'b1;
              rf[0] = slt_pkg::mk_res(slt_pkg::REC_ERROR, '0, '0, '0, '0, slt_pkg::ERR_BAD_ESC);
              rl[0] = cl_r;
              rc[0] = cc_r;
              nres = 2'd1;
            end
            default: nres = 2'd0;
          endcase
          if (!fail) begin
            rf[nres[0]] = slt_pkg::mk_res(slt_pkg::REC_TOKEN, slt_pkg::TK_END, '0, '0, '0, '0);
            rl[nres[0]] = cl_r;
            rc[nres[0]] = cc_r;
            nres = nres + 2'd1;
          end
        end
      end
      default: nres = 2'd0;
    endcase

    if (fail) halt_nxt = 1'b1;
    if (nres != 2'd0) rf[nres[1]].last = ev.eoi || fail;

    // The end of a text brings every lexer state register back to its reset value.
    if (ev.kind == slt_pkg::EV_FINISH) begin
      mode_nxt = slt_pkg::LM_IDLE;
      cl_nxt = LINE_ONE;
      cc_nxt = COL_ONE;
      tl_nxt = LINE_ONE;
      tc_nxt = COL_ONE;
      num_nxt = '0;
      dig_nxt = '0;
      halt_nxt = 1'b0;
      skip_nxt = '0;
    end
  end

  assign adv = !out_valid_r || !out_stall;
  assign ev_pop = adv && !pend_r && ev_avail;

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slt_pkg::LM_IDLE;
      cl_r   <= LINE_ONE;
      cc_r   <= COL_ONE;
      tl_r   <= LINE_ONE;
      tc_r   <= COL_ONE;
      num_r  <= '0;
      dig_r  <= '0;
      halt_r <= 1'b0;
      skip_r <= '0;
    end else if (ev_pop) begin
      mode_r <= mode_nxt;
      cl_r   <= cl_nxt;
      cc_r   <= cc_nxt;
      tl_r   <= tl_nxt;
      tc_r   <= tc_nxt;
      num_r  <= num_nxt;
      dig_r  <= dig_nxt;
      halt_r <= halt_nxt;
      skip_r <= skip_nxt;
    end
  end

  // Output register and second-result slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (adv) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (ev_avail) begin
        out_valid_r <= (nres != 2'd0);
        pend_r      <= (nres == 2'd2);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pend_r) begin
        out_f_r <= pend_f_r;
        out_l_r <= pend_l_r;
        out_c_r <= pend_c_r;
      end else begin
        out_f_r  <= rf[0];
        out_l_r  <= rl[0];
        out_c_r  <= rc[0];
        pend_f_r <= rf[1];
        pend_l_r <= rl[1];
        pend_c_r <= rc[1];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_type  = out_f_r.rtype;
  assign out_token_kind   = out_f_r.kind;
  assign out_start_line   = out_l_r;
  assign out_start_column = out_c_r;
  assign out_int_value    = out_f_r.val;
  assign out_digit_count  = out_f_r.dig;
  assign out_text_char    = out_f_r.ch;
  assign out_error_code   = out_f_r.err;
  assign out_last_of_run  = out_f_r.last;

  assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> out_valid_r)
    else $error("second result pending without a first one on the output");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (ev_pop && ev.kind == slt_pkg::EV_FINISH) |=>
                   (mode_r == slt_pkg::LM_IDLE && !halt_r))
    else $error("lexer not back in reset state after end of text");
  assert property (@(posedge clk) disable iff (!rst_n) cl_r != '0 && cc_r != '0)
    else $error("position counter reached zero");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && out_f_r.rtype == slt_pkg::REC_ERROR) |-> out_f_r.last)
    else $error("error record not marked last");

endmodule
`default_nettype wire

// ===== design/spec_language_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spec_language_tokenizer
// Streaming tokenizer: source bytes in, token, character and error records out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one source byte per transaction, with a present
// flag (clear when the transaction carries no byte) and an end-of-text mark. The output
// channel carries one record per transaction; out_last_of_run marks the last
// record caused by a given input transaction.
// A byte is scanned once two further bytes are known, so records lag the
// input by up to three transactions, and pass through the event queue and the
// output register. Throughput is one byte per cycle while the queue has room
// and no flush runs; a byte that yields two records (an identifier start, a
// brace escape, a number followed by an operator) holds the scanner while its
// second record waits in the pending slot, since the output register takes one
// record a cycle. At the end of a text the window is drained, one event per
// held byte plus one for the End token, while input is stalled.
// A four-entry event queue separates input acceptance from scanning, so a
// stalled receiver only stalls the input once that queue fills.
// Reset (rst_n low at a clock edge) empties the window and queue, drops any
// record in flight and starts a new text at line 1, column 1.
// ----------------------------------------------------------------------------
module spec_language_tokenizer #(
  parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = slt_pkg::COLUMN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_char_byte,
  input  wire logic                   in_char_present,
  input  wire logic                   in_is_last,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_record_type,
  output logic [5:0]                  out_token_kind,
  output logic [LINE_BITS-1:0]        out_start_line,
  output logic [COLUMN_BITS-1:0]      out_start_column,
  output logic [63:0]                 out_int_value,
  output logic [9:0]                  out_digit_count,
  output logic [7:0]                  out_text_char,
  output logic [2:0]                  out_error_code,
  output logic                        out_last_of_run
);

  logic            q_full, q_push, q_avail, q_pop;
  slt_pkg::event_t q_in_ev, q_head_ev;

  slt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_char_present (in_char_present),
    .in_is_last      (in_is_last),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ev            (q_in_ev)
  );

  slt_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_ev (q_in_ev),
    .full    (q_full),
    .avail   (q_avail),
    .head_ev (q_head_ev),
    .pop     (q_pop)
  );

  slt_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .ev_avail         (q_avail),
    .ev               (q_head_ev),
    .ev_pop           (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_type  (out_record_type),
    .out_token_kind   (out_token_kind),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_int_value    (out_int_value),
    .out_digit_count  (out_digit_count),
    .out_text_char    (out_text_char),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
`default_nettype wire

// ===== dv/spec_language_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spec_language_tokenizer_tb
// Self-checking bench for the tokenizer. Texts are fed one byte per
// transaction. A behavioral lexer inside the bench predicts every token,
// character and error record, and each record the block returns is compared
// field by field, bar the end-of-run flag, with the oldest prediction. A short
// table of hand-picked texts comes first. Random texts follow, built mostly from
// well-formed tokens with some broken tokens and stray bytes mixed in. Both
// channels idle at random, and the receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------
module spec_language_tokenizer_tb;

  localparam int HOLD_CYCLES  = 200;
  localparam int WATCH_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE       = 16;

  typedef struct {
    logic [1:0]  rtype;
    logic [5:0]  kind;
    logic [23:0] line;
    logic [15:0] col;
    logic [63:0] val;
    logic [9:0]  dig;
    logic [7:0]  ch;
    logic [2:0]  err;
  } token_rec_t;

  typedef struct {
    string      text;
    bit         absent_end;
    bit         typed;
    token_rec_t rec;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_byte;
  logic        in_char_present;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_record_type;
  logic [5:0]  out_token_kind;
  logic [23:0] out_start_line;
  logic [15:0] out_start_column;
  logic [63:0] out_int_value;
  logic [9:0]  out_digit_count;
  logic [7:0]  out_text_char;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;

  spec_language_tokenizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_byte(in_char_byte),
    .in_char_present(in_char_present), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_record_type(out_record_type), .out_token_kind(out_token_kind),
    .out_start_line(out_start_line), .out_start_column(out_start_column),
    .out_int_value(out_int_value), .out_digit_count(out_digit_count),
    .out_text_char(out_text_char), .out_error_code(out_error_code),
    .out_last_of_run(out_last_of_run)
  );

  always #4 clk = ~clk;

  // Operators in priority order, with their token kinds.
  string op_text [41] = '{"<=u", ">=u", ">>>", "<u", ">u", "==", "!=", "<=", ">=",
    "<<", ">>", "&&", "||", "->", "..", "/s", "%s", "{", "}", "(", ")", "[", "]",
    ",", ";", ":", ".", "?", "=", "<", ">", "+", "-", "*", "/", "%", "&", "|",
    "^", "~", "!"};
  int op_kind [41] = '{25, 27, 42, 24, 26, 18, 19, 21, 23, 40, 41, 43, 44, 16, 14,
    32, 34, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 15, 17, 20, 22, 28, 29, 30, 31, 33,
    35, 36, 37, 38, 39};

  // Lexer state mirrored by the bench.
  slt_pkg::lex_mode_t lx_mode;
  logic [7:0]  window [3];
  int          win_cnt;
  int          skip_cnt;
  logic [23:0] cur_ln, tok_ln;
  logic [15:0] cur_col, tok_col;
  logic [63:0] num_val;
  logic [9:0]  num_dig;
  bit          halted;

  token_rec_t  staged_records [$];
  token_rec_t  pending_records [$];
  int          mismatches;
  int          records_checked;
  int          items_sent;
  int          texts_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          quiet_cycles;

  // Report one mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit is_letter(input int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(input int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hexd(input int c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic int hexval(input int c);
    return is_digit(c) ? c - "0" : (c | 8'h20) - "a" + 10;
  endfunction

  task automatic emit_rec(input logic [1:0] rt, input int kind, input logic [23:0] ln,
                          input logic [15:0] col, input logic [63:0] val,
                          input int dig, input int ch, input logic [2:0] err);
    token_rec_t r;
    r.rtype = rt;
    r.kind  = kind[5:0];
    r.line  = ln;
    r.col   = col;
    r.val   = val;
    r.dig   = dig[9:0];
    r.ch    = ch[7:0];
    r.err   = err;
    staged_records = {staged_records, r};
  endtask

  task automatic lex_error(input logic [2:0] code, input logic [23:0] ln,
                           input logic [15:0] col);
    emit_rec(slt_pkg::REC_ERROR, 0, ln, col, '0, 0, 0, code);
    halted  = 1'b1;
    win_cnt = 0;
  endtask

  task automatic add_digit(input int radix, input int d);
    num_val = num_val * radix + d;
    if (num_dig < slt_pkg::DIGIT_MAX) num_dig++;
  endtask

  task automatic lexer_reset();
    lx_mode  = slt_pkg::LM_IDLE;
    win_cnt  = 0;
    skip_cnt = 0;
    cur_ln   = 1;
    cur_col  = 1;
    tok_ln   = 1;
    tok_col  = 1;
    num_val  = '0;
    num_dig  = '0;
    halted   = 1'b0;
  endtask

  // Closes a number ahead of byte c (negative at end of text).
  // Returns 1 when c must be scanned again from the idle state.
  task automatic close_number(input int c, output bit rescan);
    int d;
    d = num_dig;
    rescan = 1'b0;
    if (c >= 0 && (is_letter(c) || is_digit(c))) begin
      lex_error(slt_pkg::ERR_NUM_SUFFIX, cur_ln, cur_col);
      return;
    end
    if (lx_mode == slt_pkg::LM_HEX) d = (d >= 256) ? int'(slt_pkg::DIGIT_MAX) : d * 4;
    emit_rec(slt_pkg::REC_TOKEN, slt_pkg::TK_INT, tok_ln, tok_col, num_val, d, 0, '0);
    lx_mode = slt_pkg::LM_IDLE;
    rescan = 1'b1;
  endtask

  task automatic scan_idle(input int c, input int p1, input int p2);
    string s;
    if (c == " " || c == "\t" || c == "\r" || c == "\n") return;
    if (c == "/" && p1 == "/") begin
      lx_mode = slt_pkg::LM_LINE_CMT;
      return;
    end
    if (c == "/" && p1 == "*") begin
      lx_mode = slt_pkg::LM_BLOCK_CMT;
      skip_cnt = 1;
      return;
    end
    tok_ln = cur_ln;
    tok_col = cur_col;
    if (is_letter(c)) begin
      emit_rec(slt_pkg::REC_TOKEN, slt_pkg::TK_IDENT, tok_ln, tok_col, '0, 0, 0, '0);
      emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_IDENT, tok_ln, tok_col, '0, 0, c, '0);
      lx_mode = slt_pkg::LM_IDENT;
      return;
    end
    if (is_digit(c)) begin
      num_val = '0;
      num_dig = '0;
      if (c == "0" && (p1 == "x" || p1 == "X")) begin
        lx_mode = slt_pkg::LM_HEX_FIRST;
        skip_cnt = 1;
      end else if (c == "0" && (p1 == "b" || p1 == "B")) begin
        lx_mode = slt_pkg::LM_BIN_FIRST;
        skip_cnt = 1;
      end else begin
        add_digit(10, c - "0");
        lx_mode = slt_pkg::LM_DEC;
      end
      return;
    end
    if (c == "\"") begin
      emit_rec(slt_pkg::REC_TOKEN, slt_pkg::TK_STRING, tok_ln, tok_col, '0, 0, 0, '0);
      lx_mode = slt_pkg::LM_STR;
      return;
    end
    // First table entry that matches wins, so longer forms are listed first.
    for (int i = 0; i < 41; i++) begin
      s = op_text[i];
      if (s[0] != c) continue;
      if (s.len() >= 2 && int'(s[1]) != p1) continue;
      if (s.len() >= 3 && int'(s[2]) != p2) continue;
      emit_rec(slt_pkg::REC_TOKEN, op_kind[i], tok_ln, tok_col, '0, 0, 0, '0);
      skip_cnt = s.len() - 1;
      return;
    end
    lex_error(slt_pkg::ERR_BAD_CHAR, cur_ln, cur_col);
  endtask

  task automatic scan_byte(input int c, input int p1, input int p2);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lx_mode)
        slt_pkg::LM_IDLE: scan_idle(c, p1, p2);
        slt_pkg::LM_LINE_CMT: begin
          if (c == "\n") begin
            lx_mode = slt_pkg::LM_IDLE;
            again = 1'b1;
          end
        end
        slt_pkg::LM_BLOCK_CMT: begin
          if (c == "*" && p1 == "/") begin
            lx_mode = slt_pkg::LM_IDLE;
            skip_cnt = 1;
          end
        end
        slt_pkg::LM_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_IDENT, tok_ln, tok_col, '0, 0, c, '0);
          end else begin
            lx_mode = slt_pkg::LM_IDLE;
            again = 1'b1;
          end
        end
        slt_pkg::LM_HEX_FIRST: begin
          if (!is_hexd(c)) lex_error(slt_pkg::ERR_HEX_EMPTY, tok_ln, tok_col);
          else begin
            add_digit(16, hexval(c));
            lx_mode = slt_pkg::LM_HEX;
          end
        end
        slt_pkg::LM_BIN_FIRST: begin
          if (c != "0" && c != "1") lex_error(slt_pkg::ERR_BIN_EMPTY, tok_ln, tok_col);
          else begin
            add_digit(2, c - "0");
            lx_mode = slt_pkg::LM_BIN;
          end
        end
        slt_pkg::LM_DEC, slt_pkg::LM_HEX, slt_pkg::LM_BIN: begin
          if (c == "_") begin
          end else if (lx_mode == slt_pkg::LM_DEC && is_digit(c)) add_digit(10, c - "0");
          else if (lx_mode == slt_pkg::LM_HEX && is_hexd(c)) add_digit(16, hexval(c));
          else if (lx_mode == slt_pkg::LM_BIN && (c == "0" || c == "1")) begin
            add_digit(2, c - "0");
          end else close_number(c, again);
        end
        slt_pkg::LM_STR: begin
          if (c == "\n") lex_error(slt_pkg::ERR_OPEN_STR, tok_ln, tok_col);
          else if (c == "\"") lx_mode = slt_pkg::LM_IDLE;
          else if (c == "\\") lx_mode = slt_pkg::LM_ESC;
          else emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, tok_ln, tok_col, '0, 0, c, '0);
        end
        slt_pkg::LM_ESC: begin
          lx_mode = slt_pkg::LM_STR;
          if (c == "n") begin
            emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, tok_ln, tok_col, '0, 0, 8'h0A, '0);
          end else if (c == "t") begin
            emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, tok_ln, tok_col, '0, 0, 8'h09, '0);
          end else if (c == "\\" || c == "\"") begin
            emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, tok_ln, tok_col, '0, 0, c, '0);
          end else if (c == "{" || c == "}" || c == "[" || c == "]") begin
            // Braces and brackets keep their backslash.
            emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, tok_ln, tok_col, '0, 0, "\\", '0);
            emit_rec(slt_pkg::REC_CHAR, slt_pkg::TK_STRING, tok_ln, tok_col, '0, 0, c, '0);
          end else lex_error(slt_pkg::ERR_BAD_ESC, cur_ln, cur_col);
        end
        default: begin
          lx_mode = slt_pkg::LM_IDLE;
          again = 1'b1;
        end
      endcase
    end
  endtask

  // Scans the oldest held byte and advances the position past it.
  task automatic scan_front();
    int c, p1, p2;
    c  = window[0];
    p1 = win_cnt > 1 ? int'(window[1]) : -1;
    p2 = win_cnt > 2 ? int'(window[2]) : -1;
    if (skip_cnt > 0) skip_cnt--;
    else scan_byte(c, p1, p2);
    if (halted) return;
    if (c == "\n") begin
      if (cur_ln != '1) cur_ln++;
      cur_col = 1;
    end else if (cur_col != '1) begin
      cur_col++;
    end
    window[0] = window[1];
    window[1] = window[2];
    win_cnt--;
  endtask

  task automatic close_text();
    bit unused;
    case (lx_mode)
      slt_pkg::LM_HEX_FIRST: lex_error(slt_pkg::ERR_HEX_EMPTY, tok_ln, tok_col);
      slt_pkg::LM_BIN_FIRST: lex_error(slt_pkg::ERR_BIN_EMPTY, tok_ln, tok_col);
      slt_pkg::LM_DEC, slt_pkg::LM_HEX, slt_pkg::LM_BIN: close_number(-1, unused);
      slt_pkg::LM_STR: lex_error(slt_pkg::ERR_OPEN_STR, tok_ln, tok_col);
      slt_pkg::LM_ESC: lex_error(slt_pkg::ERR_BAD_ESC, cur_ln, cur_col);
      default: ;
    endcase
    if (!halted) emit_rec(slt_pkg::REC_TOKEN, slt_pkg::TK_END, cur_ln, cur_col, '0, 0, 0, '0);
  endtask

  // Records caused by one accepted byte land in staged_records.
  task automatic lex_item(input logic [7:0] b, input bit present, input bit last);
    if (!halted && present) begin
      if (win_cnt < 3) window[win_cnt++] = b;
      while (win_cnt >= 3 && !halted) scan_front();
    end
    if (last) begin
      if (!halted) begin
        while (win_cnt > 0 && !halted) scan_front();
        if (!halted) close_text();
      end
      lexer_reset();
    end
  endtask

  // Offer one byte, wait for the transaction, then predict its records.
  task automatic send_item(input logic [7:0] b, input bit present, input bit last,
                           input bit keep_staged);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_byte    <= b;
    in_char_present <= present;
    in_is_last      <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_item(b, present, last);
    if (!keep_staged) begin
      while (staged_records.size() > 0) begin
        pending_records = {pending_records, staged_records.pop_front()};
      end
    end
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] txt [$], input bit absent_end);
    for (int i = 0; i < txt.size(); i++) begin
      send_item(txt[i], 1'b1, !absent_end && i == txt.size() - 1, 1'b0);
    end
    if (absent_end || txt.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
    end
    texts_sent++;
  endtask

  // Sender goes quiet until every predicted record is back.
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Appends one byte to a text.
  task automatic add_byte(ref logic [7:0] txt [$], input logic [7:0] b);
    txt = {txt, b};
  endtask

  task automatic push_chars(ref logic [7:0] txt [$], input string s);
    for (int i = 0; i < s.len(); i++) add_byte(txt, s[i]);
  endtask

  // Random text: mostly well-formed tokens, some broken ones, a little noise.
  task automatic build_text(ref logic [7:0] txt [$]);
    int pieces, r, n;
    string letters, hexd, esc_set, blanks;
    letters = "abcdexyzXQ_";
    hexd = "0123456789abcdefABCDEF_";
    esc_set = "nt\\\"{}[]";
    blanks = " \t\r\n";
    pieces = $urandom_range(2, 9);
    for (int p = 0; p < pieces; p++) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        add_byte(txt, letters[$urandom_range(0, letters.len() - 1)]);
        n = $urandom_range(0, 5);
        repeat (n) add_byte(txt, $urandom_range(0, 3) == 0 ?
                                 8'(8'("0") + $urandom_range(0, 9)) :
                                 letters[$urandom_range(0, letters.len() - 1)]);
      end else if (r < 30) begin
        add_byte(txt, 8'(8'("0") + $urandom_range(1, 9)));
        n = $urandom_range(0, 24);
        repeat (n) add_byte(txt, $urandom_range(0, 7) == 0 ? 8'("_") :
                                 8'(8'("0") + $urandom_range(0, 9)));
      end else if (r < 38) begin
        push_chars(txt, $urandom_range(0, 1) ? "0x" : "0X");
        add_byte(txt, hexd[$urandom_range(0, 21)]);
        n = $urandom_range(0, 18);
        repeat (n) add_byte(txt, hexd[$urandom_range(0, hexd.len() - 1)]);
      end else if (r < 44) begin
        push_chars(txt, $urandom_range(0, 1) ? "0b" : "0B");
        n = $urandom_range(1, 10);
        repeat (n) add_byte(txt, $urandom_range(0, 5) == 0 ? 8'("_") :
                                 8'(8'("0") + $urandom_range(0, 1)));
      end else if (r < 56) begin
        add_byte(txt, "\"");
        n = $urandom_range(0, 5);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte(txt, "\\");
            add_byte(txt, esc_set[$urandom_range(0, 7)]);
          end else begin
            add_byte(txt, $urandom_range(0, 9) == 0 ? 8'($urandom_range(8'h80, 8'hFF)) :
                                                      8'($urandom_range(8'h23, 8'h5B)));
          end
        end
        add_byte(txt, "\"");
      end else if (r < 76) begin
        push_chars(txt, op_text[$urandom_range(0, 40)]);
      end else if (r < 82) begin
        add_byte(txt, blanks[$urandom_range(0, 3)]);
      end else if (r < 86) begin
        push_chars(txt, "//");
        n = $urandom_range(0, 4);
        repeat (n) add_byte(txt, 8'($urandom_range(0, 255)));
        add_byte(txt, "\n");
      end else if (r < 90) begin
        push_chars(txt, "/*");
        n = $urandom_range(0, 4);
        repeat (n) add_byte(txt, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) != 0) push_chars(txt, "*/");
      end else if (r < 96) begin
        case ($urandom_range(0, 5))
          0: push_chars(txt, "0x ");
          1: push_chars(txt, "0b2");
          2: push_chars(txt, "12q");
          3: push_chars(txt, "\"ab\\q");
          4: push_chars(txt, "\"x\n");
          default: push_chars(txt, "\"open\\");
        endcase
      end else begin
        add_byte(txt, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) != 0) add_byte(txt, $urandom_range(0, 4) == 0 ? 8'h0A : 8'h20);
    end
  endtask

  function automatic text_row_t mk_row(input string text, input bit absent_end,
                                       input bit typed, input logic [1:0] rt,
                                       input logic [5:0] kind, input int ln,
                                       input int col, input logic [2:0] err);
    text_row_t row;
    row.text = text;
    row.absent_end = absent_end;
    row.typed = typed;
    row.rec = '{rt, kind, ln[23:0], col[15:0], 64'd0, 10'd0, 8'd0, err};
    return row;
  endfunction

  // Compare every returned record with the oldest prediction.
  // The end-of-run flag is not compared: the block may place it up to three
  // input transactions later than a strict byte-by-byte scan would.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("record type %0d kind %0d with none expected",
                                  out_record_type, out_token_kind));
      end else begin
        token_rec_t e;
        e = pending_records.pop_front();
        records_checked++;
        if (out_record_type !== e.rtype || out_token_kind !== e.kind ||
            out_start_line !== e.line || out_start_column !== e.col ||
            out_int_value !== e.val || out_digit_count !== e.dig ||
            out_text_char !== e.ch || out_error_code !== e.err) begin
          report_mismatch($sformatf(
            "got t%0d k%0d %0d:%0d v%0h d%0d c%0h e%0d, want t%0d k%0d %0d:%0d v%0h d%0d c%0h e%0d",
            out_record_type, out_token_kind, out_start_line, out_start_column,
            out_int_value, out_digit_count, out_text_char, out_error_code,
            e.rtype, e.kind, e.line, e.col, e.val, e.dig, e.ch, e.err));
        end
      end
    end
  end

  // Receiver stall: random, or a counted hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("timeout: %0d records still expected", pending_records.size());
      $display("[spec_language_tokenizer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    text_row_t  rows [$];
    logic [7:0] txt [$];
    int         phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_byte = '0;
    in_char_present = 1'b0;
    in_is_last = 1'b0;
    out_stall = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    records_checked = 0;
    items_sent = 0;
    texts_sent = 0;
    send_idle_pct = 37;
    recv_idle_pct = 65;
    lexer_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts. A 0x01 byte in a row stands for NUL, which a string
    // cannot carry.
    rows = {rows, mk_row("", 1'b0, 1'b1, slt_pkg::REC_TOKEN, slt_pkg::TK_END, 1, 1, '0)};
    rows = {rows, mk_row("$", 1'b0, 1'b1, slt_pkg::REC_ERROR, 6'd0, 1, 1,
                         slt_pkg::ERR_BAD_CHAR)};
    rows = {rows, mk_row("\001", 1'b0, 1'b1, slt_pkg::REC_ERROR, 6'd0, 1, 1,
                         slt_pkg::ERR_BAD_CHAR)};
    rows = {rows, mk_row("0x", 1'b0, 1'b1, slt_pkg::REC_ERROR, 6'd0, 1, 1,
                         slt_pkg::ERR_HEX_EMPTY)};
    rows = {rows, mk_row("0b", 1'b0, 1'b1, slt_pkg::REC_ERROR, 6'd0, 1, 1,
                         slt_pkg::ERR_BIN_EMPTY)};
    rows = {rows, mk_row("1a", 1'b0, 1'b1, slt_pkg::REC_ERROR, 6'd0, 1, 2,
                         slt_pkg::ERR_NUM_SUFFIX)};
    rows = {rows, mk_row("/* x", 1'b0, 1'b1, slt_pkg::REC_TOKEN, slt_pkg::TK_END, 1, 5, '0)};
    rows = {rows, mk_row("\"\\q", 1'b0, 1'b0, '0, '0, 0, 0, '0)};
    rows = {rows, mk_row("\"x\\{\n", 1'b0, 1'b0, '0, '0, 0, 0, '0)};
    rows = {rows, mk_row("<=u>>>/s", 1'b1, 1'b0, '0, '0, 0, 0, '0)};
    foreach (rows[r]) begin
      txt.delete();
      for (int i = 0; i < rows[r].text.len(); i++) begin
        add_byte(txt, rows[r].text[i] == 8'h01 ? 8'h00 : rows[r].text[i]);
      end
      if (rows[r].typed) begin
        // Every record of these texts comes from the final byte.
        for (int i = 0; i < txt.size(); i++) begin
          send_item(txt[i], 1'b1, i == txt.size() - 1, 1'b1);
        end
        if (txt.size() == 0) send_item(8'h00, 1'b0, 1'b1, 1'b1);
        staged_records.delete();
        pending_records = {pending_records, rows[r].rec};
        texts_sent++;
      end else begin
        send_text(txt, rows[r].absent_end);
      end
    end
    drain_pause();

    // Random texts over three idle settings.
    phase = 0;
    while (items_sent < RANDOM_ITEMS + 30) begin
      if (phase == 0 && items_sent > 30 + RANDOM_ITEMS / 3) begin
        phase = 1;
        drain_pause();
        send_idle_pct = 65;
        recv_idle_pct = 37;
      end else if (phase == 1 && items_sent > 30 + 2 * RANDOM_ITEMS / 3) begin
        phase = 2;
        drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
      end
      txt.delete();
      build_text(txt);
      send_text(txt, $urandom_range(0, 3) == 0);
    end

    // Let the last records come back, then settle.
    drain_pause();
    $display("covered %0d texts, %0d input bytes, %0d records compared",
             texts_sent, items_sent, records_checked);
    $display("mix of identifiers, numbers, strings, operators, comments and all error kinds");
    if (mismatches == 0) begin
      $display("[spec_language_tokenizer] OK");
    end else begin
      $display("[spec_language_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

// ===== spec_language_tokenizer.f =====
design/slt_pkg.sv
design/slt_evq.sv
design/slt_front.sv
design/slt_back.sv
design/spec_language_tokenizer.sv
dv/spec_language_tokenizer_tb.sv
